>>> sv/mttg_pkg.sv
// Package with shared constants, types and helpers of the MT19937 token generator.
package mttg_pkg;

  localparam int unsigned STATE_WORDS_DEF = 624;
  localparam int unsigned KEY_WORDS_DEF   = 16;
  localparam int unsigned TWIST_OFFSET    = 397;

  localparam logic [31:0] TWIST_MATRIX = 32'h9908B0DF;
  localparam logic [31:0] HIGH_BIT     = 32'h80000000;
  localparam logic [31:0] LOW_BITS     = 32'h7FFFFFFF;
  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] ARRAY_MULT_A = 32'd1664525;
  localparam logic [31:0] ARRAY_MULT_B = 32'd1566083941;
  localparam logic [31:0] ARRAY_SEED   = 32'd19650218;

  // Input kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_SEEDA = 2'd1;
  localparam logic [1:0] KIND_SEEDW = 2'd2;
  localparam logic [1:0] KIND_DRAW = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_SHIFT_U = 3'd0;
  localparam logic [2:0] REG_SHIFT_S = 3'd1;
  localparam logic [2:0] REG_MASK_B  = 3'd2;
  localparam logic [2:0] REG_SHIFT_T = 3'd3;
  localparam logic [2:0] REG_MASK_C  = 3'd4;
  localparam logic [2:0] REG_SHIFT_L = 3'd5;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SW_RD,     // seed word: read previous word
    ST_SW_WAIT,
    ST_SW_MUL,
    ST_SW_WR,
    ST_SA_RD,     // key array mixing: read i-1 and i
    ST_SA_WAIT,
    ST_SA_MUL,
    ST_SA_WR,
    ST_SA_FIX,    // copy word 623 into word 0
    ST_SA_FIXW,
    ST_SA_HIGH,
    ST_RG_RD,     // regeneration of one word
    ST_RG_WAIT,
    ST_RG_WR,
    ST_DR_RD,     // draw read
    ST_DR_WAIT,
    ST_DR_T1,
    ST_DR_T2,
    ST_OUT
  } mttg_state_t;

  // Tempering settings handed to the tempering unit
  typedef struct packed {
    logic [4:0]  shift_u;
    logic [4:0]  shift_s;
    logic [31:0] mask_b;
    logic [4:0]  shift_t;
    logic [31:0] mask_c;
    logic [4:0]  shift_l;
  } mttg_temper_t;

endpackage

>>> sv/mersenne_twister_token_generator_unit.sv
// Top level of the MT19937 token generator with configurable tempering.
// Each request is taken when in_tready is high; the block then works on it alone.
// A load key word is taken without leaving idle, and the next request may follow at once.
// A draw reads and tempers one state word; the 624-word state is regenerated first
// on every 624th draw and on the first one after seeding. Word seeds and key-array
// seeds are paced by one shared 32x32 multiplier and the state memory's single write
// port, used once per state word per pass. No clearing pass runs after reset and the
// state memory has no reset: a flag makes unseeded draws return zero.
module mersenne_twister_token_generator_unit
  import mttg_pkg::*;
#(
  parameter int unsigned KEY_WORDS_MAX = KEY_WORDS_DEF,
  parameter int unsigned STATE_WORDS   = STATE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: kind[1:0], key_slot[5:2], word_value[37:6], key_count[42:38], zero fill
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: token[31:0]
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned AW  = $clog2(STATE_WORDS);
  localparam int unsigned KAW = (KEY_WORDS_MAX > 1) ? $clog2(KEY_WORDS_MAX) : 1;
  localparam int unsigned CW  = $clog2(KEY_WORDS_MAX + 1) + 1;
  localparam logic [AW-1:0] LAST = AW'(STATE_WORDS - 1);

  mttg_state_t state_r, state_nxt;
  mttg_temper_t tcfg_r;

  logic [CW-1:0] count_r;
  logic [AW-1:0] i_r, i_nxt;
  logic [KAW-1:0] j_r, j_nxt;
  logic [AW:0]   k_r, k_nxt;
  logic          phase2_r, phase2_nxt;
  logic [AW:0]   pos_r, pos_nxt;
  logic          seeded_r, seeded_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [31:0]   out_r;
  logic          out_v_r;

  logic [31:0]   key_r [KEY_WORDS_MAX];

  // Memory signals
  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  logic [31:0]   wdata, rda, rdb;

  mttg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
  );

  // Shared multiplier: fixed operand p ^ p>>30, constant chosen by the sequencer
  logic [31:0] mul_a, mul_b, mul_p;
  assign mul_p = 32'(mul_a * mul_b);

  logic [31:0] tmp_in, tmp_out;
  mttg_temper u_temper (
    .cfg(tcfg_r), .second(state_r == ST_DR_T2), .din(tmp_in), .dout(tmp_out)
  );
  assign tmp_in = cur_r;

  logic [4:0] cnt_in;
  logic [CW-1:0] cnt_sat;
  always_comb begin
    cnt_in = in_tdata[42:38];
    if (cnt_in == 5'd0) cnt_sat = CW'(1);
    else if (32'(cnt_in) > KEY_WORDS_MAX) cnt_sat = CW'(KEY_WORDS_MAX);
    else cnt_sat = CW'(cnt_in);
  end

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // Registers: configuration, key store, output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcfg_r <= '{5'd13, 5'd9, 32'hB5A7C4E0, 5'd17, 32'hD3E40000, 5'd15};
      for (int n = 0; n < KEY_WORDS_MAX; n++) key_r[n] <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SHIFT_U: tcfg_r.shift_u <= cfg_data[4:0];
          REG_SHIFT_S: tcfg_r.shift_s <= cfg_data[4:0];
          REG_MASK_B:  tcfg_r.mask_b  <= cfg_data;
          REG_SHIFT_T: tcfg_r.shift_t <= cfg_data[4:0];
          REG_MASK_C:  tcfg_r.mask_c  <= cfg_data;
          REG_SHIFT_L: tcfg_r.shift_l <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_acc && in_tdata[1:0] == KIND_LOAD &&
          32'(in_tdata[5:2]) < KEY_WORDS_MAX) begin
        key_r[KAW'(in_tdata[5:2])] <= in_tdata[37:6];
      end
      if (state_r == ST_OUT && !out_v_r) begin
        out_v_r <= 1'b1;
        out_r   <= seeded_r ? cur_r : 32'd0;
      end else if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pos_r    <= (AW+1)'(STATE_WORDS + 1);
      seeded_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      seeded_r <= seeded_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt; phase2_r <= phase2_nxt;
    acc_r <= acc_nxt; cur_r <= cur_nxt;
    if (in_acc) begin
      count_r <= cnt_sat;
    end
  end

  logic [31:0] p_mix;
  assign p_mix = rda ^ (rda >> 30);

  // Next state and datapath control
  always_comb begin
    state_nxt = state_r; pos_nxt = pos_r; seeded_nxt = seeded_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; phase2_nxt = phase2_r;
    acc_nxt = acc_r; cur_nxt = cur_r;
    we = 1'b0; waddr = i_r; wdata = acc_r; ra = i_r; rb = i_r;
    mul_a = p_mix; mul_b = INIT_MULT;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_tdata[1:0])
            KIND_LOAD: state_nxt = ST_IDLE;
            KIND_SEEDW: begin
              we = 1'b1; waddr = '0; wdata = in_tdata[37:6];
              i_nxt = AW'(1); phase2_nxt = 1'b0; state_nxt = ST_SW_RD;
            end
            KIND_SEEDA: begin
              we = 1'b1; waddr = '0; wdata = ARRAY_SEED;
              i_nxt = AW'(1); phase2_nxt = 1'b1; state_nxt = ST_SW_RD;
            end
            default: begin
              if (pos_r >= (AW+1)'(STATE_WORDS)) begin
                i_nxt = '0; state_nxt = ST_RG_RD;
              end else begin
                state_nxt = ST_DR_RD;
              end
            end
          endcase
        end
      end
      // Word seed: w[i] = M * (p ^ p>>30) + i
      ST_SW_RD: begin ra = i_r - AW'(1); state_nxt = ST_SW_WAIT; end
      // Keep the read address so the registered data still holds word i-1.
      ST_SW_WAIT: begin ra = i_r - AW'(1); state_nxt = ST_SW_MUL; end
      ST_SW_MUL: begin
        acc_nxt = mul_p; state_nxt = ST_SW_WR;
      end
      ST_SW_WR: begin
        we = 1'b1; wdata = acc_r + 32'(i_r);
        if (i_r == LAST) begin
          pos_nxt = (AW+1)'(STATE_WORDS); seeded_nxt = 1'b1;
          if (phase2_r) begin
            i_nxt = AW'(1); j_nxt = '0; phase2_nxt = 1'b0;
            k_nxt = (32'(count_r) > STATE_WORDS) ? (AW+1)'(count_r) : (AW+1)'(STATE_WORDS);
            state_nxt = ST_SA_RD;
          end else state_nxt = ST_IDLE;
        end else begin
          i_nxt = i_r + AW'(1); state_nxt = ST_SW_RD;
        end
      end
      // Key array mixing, two passes
      ST_SA_RD: begin
        ra = i_r - AW'(1); rb = i_r; state_nxt = ST_SA_WAIT;
      end
      ST_SA_WAIT: begin
        ra = i_r - AW'(1); rb = i_r; state_nxt = ST_SA_MUL;
      end
      ST_SA_MUL: begin
        mul_b = phase2_r ? ARRAY_MULT_B : ARRAY_MULT_A;
        cur_nxt = rdb; acc_nxt = mul_p; state_nxt = ST_SA_WR;
      end
      ST_SA_WR: begin
        we = 1'b1;
        wdata = phase2_r ? ((cur_r ^ acc_r) - 32'(i_r))
                         : ((cur_r ^ acc_r) + key_r[j_r] + 32'(j_r));
        if (!phase2_r) j_nxt = (32'(j_r) + 1 >= 32'(count_r)) ? '0 : j_r + KAW'(1);
        k_nxt = k_r - (AW+1)'(1);
        if (i_r == LAST) begin
          i_nxt = AW'(1); state_nxt = ST_SA_FIX;
        end else begin
          i_nxt = i_r + AW'(1);
          state_nxt = ST_SA_RD;
          if (k_r == (AW+1)'(1)) begin
            if (phase2_r) state_nxt = ST_SA_HIGH;
            else begin phase2_nxt = 1'b1; k_nxt = (AW+1)'(STATE_WORDS - 1); end
          end
        end
      end
      ST_SA_FIX: begin ra = LAST; state_nxt = ST_SA_FIXW; end
      ST_SA_FIXW: begin
        // memory read of word 623 arrives now; rewrite after its latency
        acc_nxt = rda; state_nxt = ST_SA_HIGH;
        we = 1'b0;
        if (k_r != '0) begin
          // wait handled by storing and writing next cycle
        end
      end
      ST_SA_HIGH: begin
        // either the word-0 copy or the final high-bit write
        we = 1'b1; waddr = '0;
        if (k_r == '0 && phase2_r && i_r != AW'(1)) wdata = HIGH_BIT;
        else if (k_r == '0 && phase2_r) wdata = HIGH_BIT;
        else wdata = acc_r;
        if (k_r == '0 && phase2_r) begin
          state_nxt = ST_IDLE;
        end else begin
          if (k_r == '0) begin phase2_nxt = 1'b1; k_nxt = (AW+1)'(STATE_WORDS - 1); end
          state_nxt = ST_SA_RD;
          if (k_r == '0 && phase2_r) state_nxt = ST_IDLE;
        end
      end
      // Regeneration of word i
      ST_RG_RD: begin
        ra = i_r;
        rb = (i_r == LAST) ? '0 : i_r + AW'(1);
        state_nxt = ST_RG_WAIT;
      end
      ST_RG_WAIT: begin
        ra = (32'(i_r) + TWIST_OFFSET >= STATE_WORDS)
             ? AW'(32'(i_r) + TWIST_OFFSET - STATE_WORDS) : AW'(32'(i_r) + TWIST_OFFSET);
        acc_nxt = (rda & HIGH_BIT) | (rdb & LOW_BITS);
        state_nxt = ST_RG_WR;
      end
      ST_RG_WR: begin
        we = 1'b1;
        wdata = rda ^ (acc_r >> 1) ^ (acc_r[0] ? TWIST_MATRIX : 32'd0);
        if (i_r == LAST) begin
          pos_nxt = '0; state_nxt = ST_DR_RD;
        end else begin
          i_nxt = i_r + AW'(1); state_nxt = ST_RG_RD;
        end
      end
      // Draw and temper
      ST_DR_RD: begin ra = AW'(pos_r); state_nxt = ST_DR_WAIT; end
      ST_DR_WAIT: begin cur_nxt = rda; state_nxt = ST_DR_T1; end
      ST_DR_T1: begin cur_nxt = tmp_out; state_nxt = ST_DR_T2; end
      ST_DR_T2: begin
        cur_nxt = tmp_out; pos_nxt = pos_r + (AW+1)'(1); state_nxt = ST_OUT;
      end
      ST_OUT: if (!out_v_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> sv/mttg_ram.sv
// Generic single-port-write, two-port-read RAM with registered read data.
module mttg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> sv/mttg_temper.sv
// Tempering step unit: applies one of two tempering halves per cycle.
module mttg_temper
  import mttg_pkg::*;
(
  input  mttg_temper_t cfg,
  input  logic         second,
  input  logic [31:0]  din,
  output logic [31:0]  dout
);

  logic [31:0] y1;

  // First half does the u and s steps, second half the t and l steps
  always_comb begin
    if (!second) begin
      y1   = din ^ (din >> cfg.shift_u);
      dout = y1 ^ ((y1 << cfg.shift_s) & cfg.mask_b);
    end else begin
      y1   = din ^ ((din << cfg.shift_t) & cfg.mask_c);
      dout = y1 ^ (y1 >> cfg.shift_l);
    end
  end

endmodule

>>> sv/mttg_checker.sv
// Port-level checker for the MT19937 token generator, bound to the top level.
module mttg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // Result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("token changed while stalled");

  // A result never appears in the cycle right after a request is taken
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared right after a request");

  // No output right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind mersenne_twister_token_generator_unit mttg_checker u_mttg_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

>>> bench/testbench.sv
// Self-checking testbench for the MT19937 token generator with configurable tempering.
`timescale 1ns / 100ps

module testbench;
  import mttg_pkg::*;

  localparam int unsigned N_WORDS    = 624;
  localparam int unsigned KEY_SLOTS  = 16;
  localparam int unsigned SEED_WAIT  = 12000;
  localparam int unsigned CYCLE_CAP  = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  mersenne_twister_token_generator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the generator state and the tempering settings.
  logic [31:0]  mt_words [N_WORDS];
  int unsigned  mt_pos;
  logic [31:0]  key_words [KEY_SLOTS];
  mttg_temper_t temper;

  logic [31:0] token_queue [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("mersenne_twister_token_generator_unit test failed");
      $finish;
    end
  end

  // Result side back-pressure in random bursts while idle_on is set.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted token with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (token_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token %h", out_tdata);
      end else begin
        if (out_tdata !== token_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("token mismatch: expected %h, actual %h", token_queue[0], out_tdata);
        end
        void'(token_queue.pop_front());
      end
    end
  end

  // Predictor: seeding, regeneration and tempering.
  function automatic void mt_seed_word(logic [31:0] s);
    logic [31:0] p;
    mt_words[0] = s;
    for (int unsigned n = 1; n < N_WORDS; n++) begin
      p = mt_words[n - 1];
      mt_words[n] = INIT_MULT * (p ^ (p >> 30)) + n;
    end
    mt_pos = N_WORDS;
  endfunction

  function automatic void mt_seed_keys(logic [4:0] count_in);
    int unsigned count;
    int unsigned i;
    int unsigned j;
    logic [31:0] p;
    count = (count_in == 0) ? 1 : count_in;
    if (count > KEY_SLOTS) count = KEY_SLOTS;
    i = 1;
    j = 0;
    mt_seed_word(ARRAY_SEED);
    for (int unsigned k = N_WORDS; k > 0; k--) begin
      p = mt_words[i - 1];
      mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * ARRAY_MULT_A)) + key_words[j] + j;
      i++;
      j++;
      if (i >= N_WORDS) begin
        mt_words[0] = mt_words[N_WORDS - 1];
        i = 1;
      end
      if (j >= count) j = 0;
    end
    for (int unsigned k = N_WORDS - 1; k > 0; k--) begin
      p = mt_words[i - 1];
      mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * ARRAY_MULT_B)) - i;
      i++;
      if (i >= N_WORDS) begin
        mt_words[0] = mt_words[N_WORDS - 1];
        i = 1;
      end
    end
    mt_words[0] = HIGH_BIT;
  endfunction

  function automatic logic [31:0] mt_next_token();
    logic [31:0] y;
    logic [31:0] nxt;
    if (mt_pos >= N_WORDS) begin
      for (int unsigned n = 0; n < N_WORDS; n++) begin
        nxt = mt_words[(n + 1) % N_WORDS];
        y = (mt_words[n] & HIGH_BIT) | (nxt & LOW_BITS);
        mt_words[n] = mt_words[(n + TWIST_OFFSET) % N_WORDS] ^ (y >> 1) ^
                      (y[0] ? TWIST_MATRIX : 32'h0);
      end
      mt_pos = 0;
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ (y >> temper.shift_u);
    y = y ^ ((y << temper.shift_s) & temper.mask_b);
    y = y ^ ((y << temper.shift_t) & temper.mask_c);
    y = y ^ (y >> temper.shift_l);
    return y;
  endfunction

  // Send one request and update the prediction once it is taken.
  task automatic send_item(logic [1:0] kind, logic [3:0] slot, logic [31:0] word,
                           logic [4:0] count);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, count, word, slot, kind};
    do @(posedge clk); while (!in_tready);
    case (kind)
      KIND_LOAD:  key_words[slot] = word;
      KIND_SEEDA: mt_seed_keys(count);
      KIND_SEEDW: mt_seed_word(word);
      default:    token_queue.push_back(mt_next_token());
    endcase
  endtask

  task automatic draw_tokens(int unsigned n);
    repeat (n) send_item(KIND_DRAW, 4'($urandom()), $urandom(), 5'($urandom()));
  endtask

  // Wait until the block is idle: all tokens back and any seed finished.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk);
    repeat (SEED_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SHIFT_U: temper.shift_u = value[4:0];
      REG_SHIFT_S: temper.shift_s = value[4:0];
      REG_MASK_B:  temper.mask_b = value;
      REG_SHIFT_T: temper.shift_t = value[4:0];
      REG_MASK_C:  temper.mask_c = value;
      REG_SHIFT_L: temper.shift_l = value[4:0];
      default: ;
    endcase
  endtask

  task automatic set_temper(logic [31:0] u, logic [31:0] s, logic [31:0] b,
                            logic [31:0] t, logic [31:0] c, logic [31:0] l);
    cfg_write(REG_SHIFT_U, u);
    cfg_write(REG_SHIFT_S, s);
    cfg_write(REG_MASK_B, b);
    cfg_write(REG_SHIFT_T, t);
    cfg_write(REG_MASK_C, c);
    cfg_write(REG_SHIFT_L, l);
    cfg_valid <= 1'b0;
  endtask

  // Draws before any seed come from the all-zero state.
  task automatic test_unseeded_draws();
    draw_tokens(3);
  endtask

  // Key store extremes and key counts of zero, above the maximum and at the maximum.
  task automatic test_key_array_seeds();
    send_item(KIND_LOAD, 4'd0, 32'hFFFF_FFFF, 5'd0);
    send_item(KIND_LOAD, 4'd15, 32'h0, 5'd31);
    send_item(KIND_LOAD, 4'd7, $urandom(), 5'd0);
    send_item(KIND_SEEDA, 4'd15, 32'h0, 5'd0);
    draw_tokens(2);
    send_item(KIND_SEEDA, 4'd0, 32'hFFFF_FFFF, 5'd31);
    draw_tokens(2);
    send_item(KIND_SEEDA, 4'd0, 32'h0, 5'd16);
    draw_tokens(1);
  endtask

  task automatic test_word_seeds();
    send_item(KIND_SEEDW, 4'd0, 32'h0, 5'd0);
    draw_tokens(2);
    send_item(KIND_SEEDW, 4'd15, 32'hFFFF_FFFF, 5'd31);
    draw_tokens(2);
  endtask

  // Extreme tempering settings, upper data bits set on the shift registers.
  task automatic test_temper_extremes();
    settle();
    set_temper(32'hFFFF_FFE0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
    draw_tokens(3);
    settle();
    set_temper(32'hFFFF_FFFF, 32'd31, 32'h0, 32'd31, 32'h0, 32'h1F);
    draw_tokens(3);
    settle();
    set_temper(13, 9, 32'hB5A7C4E0, 17, 32'hD3E40000, 15);
  endtask

  // A long run of draws crosses a regeneration without reseeding.
  task automatic test_long_sequence();
    send_item(KIND_SEEDW, 4'($urandom()), $urandom(), 5'($urandom()));
    draw_tokens(650);
  endtask

  // Mostly draws with occasional key loads and reseeds, random tempering.
  task automatic test_random_mix();
    int unsigned pick;
    settle();
    set_temper($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    for (int unsigned n = 0; n < 360; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        send_item(KIND_LOAD, 4'($urandom()), $urandom(), 5'($urandom()));
      else if (pick < 10)
        send_item(KIND_SEEDA, 4'($urandom()), $urandom(), 5'($urandom()));
      else if (pick < 12)
        send_item(KIND_SEEDW, 4'($urandom()), $urandom(), 5'($urandom()));
      else
        send_item(KIND_DRAW, 4'($urandom()), $urandom(), 5'($urandom()));
    end
  endtask

  // Closing stretch at full rate.
  task automatic test_full_rate();
    idle_on = 1'b0;
    draw_tokens(30);
  endtask

  initial begin
    for (int unsigned n = 0; n < N_WORDS; n++) mt_words[n] = '0;
    for (int unsigned n = 0; n < KEY_SLOTS; n++) key_words[n] = '0;
    mt_pos = N_WORDS + 1;
    temper = '{shift_u: 5'd13, shift_s: 5'd9, mask_b: 32'hB5A7C4E0,
               shift_t: 5'd17, mask_c: 32'hD3E40000, shift_l: 5'd15};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_temper(13, 9, 32'hB5A7C4E0, 17, 32'hD3E40000, 15);

    test_unseeded_draws();
    test_key_array_seeds();
    test_word_seeds();
    test_temper_extremes();
    test_long_sequence();
    test_random_mix();
    test_full_rate();

    in_tvalid <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && token_queue.size() == 0) begin
      $display("mersenne_twister_token_generator_unit test passed");
    end else begin
      $display("mersenne_twister_token_generator_unit test failed");
    end
    $finish;
  end

endmodule
